/* rtl/rsr_pkg.sv */
`timescale 1ns / 1ps
package rsr_pkg;

  localparam int TEXT_MAX_DEF    = 64;
  localparam int PATTERN_MAX_DEF = 8;

  localparam int CHAR_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int USER_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;

  localparam logic [LEN_W-1:0] PAT_LEN_RESET = 4'd1;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_CMP_RD   = 5'b00010,
    ST_CMP_CHK  = 5'b00100,
    ST_EMIT_RD  = 5'b01000,
    ST_EMIT_OUT = 5'b10000
  } rsr_state_t;

  typedef struct packed {
    logic push;
    logic ovf_set;
    logic cmp_start;
    logic k_inc;
    logic hit;
    logic emit_start;
    logic finish;
  } rsr_cmd_t;

  typedef struct packed {
    logic full;
    logic need_cmp;
    logic match;
    logic k_end;
    logic emit_done;
  } rsr_status_t;

endpackage

/* rtl/rsr_ctrl.sv */
`timescale 1ns / 1ps
module rsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  rsr_pkg::rsr_status_t status,
  output rsr_pkg::rsr_cmd_t    cmd
);
  import rsr_pkg::*;

  rsr_state_t state_r, state_nxt;
  logic       last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          last_nxt = in_tlast;
          if (status.full) begin
            cmd.ovf_set = 1'b1;
          end else begin
            cmd.push = 1'b1;
          end
          if (!status.full && status.need_cmp) begin
            cmd.cmp_start = 1'b1;
            state_nxt     = ST_CMP_RD;
          end else if (in_tlast) begin
            cmd.emit_start = 1'b1;
            state_nxt      = ST_EMIT_RD;
          end
        end
      end
      ST_CMP_RD: begin
        state_nxt = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (status.match && !status.k_end) begin
          cmd.k_inc = 1'b1;
          state_nxt = ST_CMP_RD;
        end else begin
          cmd.hit = status.match;
          if (last_r) begin
            cmd.emit_start = 1'b1;
            state_nxt      = ST_EMIT_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (status.emit_done) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/rsr_dp.sv */
`timescale 1ns / 1ps
module rsr_dp #(
  parameter int TEXT_MAX    = rsr_pkg::TEXT_MAX_DEF,
  parameter int PATTERN_MAX = rsr_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rsr_pkg::CHAR_W-1:0]    in_char,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsr_pkg::PAT_W-1:0]     cfg_data,
  output logic [rsr_pkg::CHAR_W-1:0]    out_char,
  output logic                          out_last,
  output logic [rsr_pkg::USER_W-1:0]    out_user,
  input  rsr_pkg::rsr_cmd_t             cmd,
  output rsr_pkg::rsr_status_t          status
);
  import rsr_pkg::*;

  localparam int AW = (TEXT_MAX > 1) ? $clog2(TEXT_MAX) : 1;
  localparam int CW = $clog2(TEXT_MAX + 1);
  localparam int KW = (AW > 3) ? AW : 3;
  localparam int MW = CW + LEN_W;

  logic [CHAR_W-1:0] mem [TEXT_MAX];
  logic [CHAR_W-1:0] rdata_r;

  logic [PAT_W-1:0]  pat_chars_r;
  logic [LEN_W-1:0]  pat_len_r;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  len_r;

  logic [CW-1:0]     count_r, count_nxt, count_inc;
  logic [AW-1:0]     base_r, base_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic              removed_r, removed_nxt;
  logic              ovf_r, ovf_nxt;
  logic [AW-1:0]     rd_addr;
  logic [CHAR_W-1:0] pat_byte;
  logic              empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_chars_r <= '0;
      pat_len_r   <= PAT_LEN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PATTERN_CHARS) begin
        pat_chars_r <= cfg_data;
      end else if (cfg_index == CFG_PATTERN_LENGTH) begin
        pat_len_r <= cfg_data[LEN_W-1:0];
      end
    end
  end

  always_comb begin
    if (pat_len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(PATTERN_MAX)) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = pat_len_r;
    end
  end

  assign count_inc = count_r + 1'b1;
  assign rd_addr   = base_r + k_r[AW-1:0];
  assign pat_byte  = pat_chars_r[8 * k_r[2:0] +: 8];
  assign empty     = (count_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[count_r[AW-1:0]] <= in_char;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    count_nxt   = count_r;
    base_nxt    = base_r;
    k_nxt       = k_r;
    removed_nxt = removed_r;
    ovf_nxt     = ovf_r;
    if (cmd.push) begin
      count_nxt = count_inc;
    end
    if (cmd.ovf_set) begin
      ovf_nxt = 1'b1;
    end
    if (cmd.cmp_start) begin
      base_nxt = AW'(MW'(count_inc) - MW'(len_eff));
      k_nxt    = '0;
    end
    if (cmd.emit_start) begin
      base_nxt = '0;
      k_nxt    = '0;
    end
    if (cmd.k_inc) begin
      k_nxt = k_r + 1'b1;
    end
    if (cmd.hit) begin
      count_nxt   = CW'(base_r);
      removed_nxt = 1'b1;
    end
    if (cmd.finish) begin
      count_nxt   = '0;
      removed_nxt = 1'b0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      base_r    <= '0;
      k_r       <= '0;
      removed_r <= 1'b0;
      ovf_r     <= 1'b0;
      len_r     <= LEN_W'(1);
    end else begin
      count_r   <= count_nxt;
      base_r    <= base_nxt;
      k_r       <= k_nxt;
      removed_r <= removed_nxt;
      ovf_r     <= ovf_nxt;
      if (cmd.cmp_start) begin
        len_r <= len_eff;
      end
    end
  end

  assign status.full      = (count_r >= CW'(TEXT_MAX));
  assign status.need_cmp  = (MW'(count_inc) >= MW'(len_eff));
  assign status.match     = (rdata_r == pat_byte);
  assign status.k_end     = (k_r == KW'(len_r - 1'b1));
  assign status.emit_done = empty || ((MW'(k_r) + 1'b1) == MW'(count_r));

  assign out_char = empty ? '0 : rdata_r;
  assign out_last = status.emit_done;
  assign out_user = {ovf_r, removed_r, empty};

endmodule

/* rtl/repeated_substring_removal.sv */
`timescale 1ns / 1ps
// Removes every occurrence of a programmable pattern of 1 to 8 characters from a
// text, including occurrences that earlier removals create.
// The in_ channel takes one character per request, in_tlast on the final one.
// The out_ channel returns the surviving characters in order after the final
// character, with out_tlast on the last one; an empty result is one request
// with the empty flag set. The cfg_ channel writes the pattern bytes (index 0)
// and the pattern length (index 1); it is always ready. The user must write
// the pattern only while the block is idle; the block does not enforce this.
// A character is pushed onto the stack; when the stack then holds at least the
// pattern length, the stack top is compared one character at a time through the
// stack memory's read port, stopping at the first mismatch or a full match.
// After the final character each result is read from the memory, then output.
// Characters beyond TEXT_MAX held are dropped and flagged as overflow.
// Reset clears the stack count, the flags and the registers; no clearing pass
// is needed. A stalled receiver holds the current result, and no character is
// taken until the run has been delivered.
module repeated_substring_removal #(
  parameter int TEXT_MAX    = rsr_pkg::TEXT_MAX_DEF,
  parameter int PATTERN_MAX = rsr_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // text_char
  input  logic                          in_tlast,   // text_last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // out_char
  output logic                          out_tlast,  // out_last
  output logic [rsr_pkg::USER_W-1:0]    out_tuser,  // out_empty, removed_any, overflowed
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rsr_pkg::PAT_W-1:0]     cfg_data
);
  import rsr_pkg::*;

  rsr_cmd_t    cmd;
  rsr_status_t status;

  rsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  rsr_dp #(
    .TEXT_MAX    (TEXT_MAX),
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_char   (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_char  (out_tdata),
    .out_last  (out_tlast),
    .out_user  (out_tuser),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
